>>> hw/rtl/apct_pkg.sv
// apct_pkg: constants, event codes and shared types of the aabb pair contact tracker
// no dependencies; used by apct_geom, apct_track and the top level by scoped names

package apct_pkg;

  localparam int unsigned MaxColliders = 64;
  localparam int unsigned TableDepth   = MaxColliders * MaxColliders;
  localparam int unsigned IdxW         = $clog2(TableDepth);
  localparam int unsigned IdW          = 6;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned SizeW        = 16;
  localparam int unsigned DiffW        = CoordW + 1;
  localparam int unsigned SumW         = SizeW + 1;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvBegin = 2'd1,
    EvStay  = 2'd2,
    EvEnd   = 2'd3
  } contact_ev_e;

  typedef logic [IdxW-1:0] idx_t;

  // advance strobes of the pipeline, driven by the top level
  typedef struct packed {
    logic acc;   // item enters stage 1
    logic adv2;  // stage 1 moves to stage 2
    logic adv3;  // stage 2 moves to the output stage
  } pipe_ctrl_t;

endpackage

>>> hw/rtl/apct_ram.sv
// apct_ram: generic single write port, single read port ram with registered read
// no dependencies

module apct_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old content when the same address is written in the same cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/apct_geom.sv
// apct_geom: overlap test datapath, centre differences and size sums, then
// absolute values, then the compare; depends on apct_pkg

module apct_geom (
  input  logic                              clk_i,
  input  apct_pkg::pipe_ctrl_t              ctrl_i,
  input  logic signed [apct_pkg::CoordW-1:0] first_cx_i,
  input  logic signed [apct_pkg::CoordW-1:0] first_cy_i,
  input  logic signed [apct_pkg::CoordW-1:0] second_cx_i,
  input  logic signed [apct_pkg::CoordW-1:0] second_cy_i,
  input  logic [apct_pkg::SizeW-1:0]        first_w_i,
  input  logic [apct_pkg::SizeW-1:0]        first_h_i,
  input  logic [apct_pkg::SizeW-1:0]        second_w_i,
  input  logic [apct_pkg::SizeW-1:0]        second_h_i,
  output logic                              overlap_o
);

  logic signed [apct_pkg::DiffW-1:0] dx_d, dx_q, dy_d, dy_q;
  logic [apct_pkg::SumW-1:0]         sw_d, sw1_q, sh_d, sh1_q, sw2_q, sh2_q;
  logic [apct_pkg::CoordW-1:0]       adx_d, adx_q, ady_d, ady_q;

  // stage 1: differences and sums at full width
  always_comb begin
    dx_d = apct_pkg::DiffW'(first_cx_i) - apct_pkg::DiffW'(second_cx_i);
    dy_d = apct_pkg::DiffW'(first_cy_i) - apct_pkg::DiffW'(second_cy_i);
    sw_d = apct_pkg::SumW'(first_w_i) + apct_pkg::SumW'(second_w_i);
    sh_d = apct_pkg::SumW'(first_h_i) + apct_pkg::SumW'(second_h_i);
  end

  // stage 2: magnitudes fit in the coordinate width
  always_comb begin
    adx_d = dx_q[apct_pkg::DiffW-1] ? apct_pkg::CoordW'(-dx_q) : apct_pkg::CoordW'(dx_q);
    ady_d = dy_q[apct_pkg::DiffW-1] ? apct_pkg::CoordW'(-dy_q) : apct_pkg::CoordW'(dy_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      sw1_q <= sw_d;
      sh1_q <= sh_d;
    end
    if (ctrl_i.adv2) begin
      adx_q <= adx_d;
      ady_q <= ady_d;
      sw2_q <= sw1_q;
      sh2_q <= sh1_q;
    end
  end

  // 2*|d| <= sum on both axes
  assign overlap_o = ({adx_q, 1'b0} <= sw2_q) && ({ady_q, 1'b0} <= sh2_q);

endmodule

>>> hw/rtl/apct_track.sv
// apct_track: per-pair contact bit table, clearing pass, forwarding of
// in-flight updates and event decode; depends on apct_pkg and apct_ram

module apct_track (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  apct_pkg::pipe_ctrl_t         ctrl_i,
  input  logic [apct_pkg::IdW-1:0]     first_id_i,
  input  logic [apct_pkg::IdW-1:0]     second_id_i,
  input  logic                         either_dead_i,
  input  logic                         overlap_i,
  output logic                         clear_done_o,
  output logic [1:0]                   contact_event_o,
  output logic                         overlapping_o
);

  apct_pkg::idx_t idx_in, idx1_q, idx2_q, clr_addr_q, clr_addr_d;
  logic           inr_in, inr1_q, inr2_q;
  logic           dead1_q, dead2_q;
  logic           fwd1_q, fwdv1_q, fwd1_d;
  logic           was1, was2_q, was2_d;
  logic           clr_done_q, clr_done_d;
  logic           item_we, ram_we, ram_wdata, ram_rdata;
  apct_pkg::idx_t ram_waddr;
  apct_pkg::contact_ev_e ev_d, ev_q;
  logic           ov_q;

  assign inr_in = (32'(first_id_i) < 32'(apct_pkg::MaxColliders)) &&
                  (32'(second_id_i) < 32'(apct_pkg::MaxColliders));
  assign idx_in = apct_pkg::IdxW'(first_id_i) * apct_pkg::IdxW'(apct_pkg::MaxColliders) +
                  apct_pkg::IdxW'(second_id_i);

  // the item leaving stage 2 writes its new bit
  assign item_we = ctrl_i.adv3 && inr2_q;

  // bypass writes that the ram read of a younger item did not see
  assign fwd1_d = item_we && inr_in && (idx_in == idx2_q);
  assign was1   = fwd1_q ? fwdv1_q : ram_rdata;
  assign was2_d = (item_we && inr1_q && (idx1_q == idx2_q)) ? overlap_i : was1;

  // clearing pass sweeps the table once after reset
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_done_d = clr_done_q;
    if (!clr_done_q) begin
      if (32'(clr_addr_q) == apct_pkg::TableDepth - 1) begin
        clr_done_d = 1'b1;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_done_q <= 1'b0;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_done_q <= clr_done_d;
    end
  end

  assign ram_we    = !clr_done_q || item_we;
  assign ram_waddr = clr_done_q ? idx2_q : clr_addr_q;
  assign ram_wdata = clr_done_q && overlap_i;

  apct_ram #(
    .Width (1),
    .Depth (apct_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl_i.acc),
    .raddr_i (idx_in),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ev_d = apct_pkg::EvNone;
    if (inr2_q) begin
      if (overlap_i) begin
        if (!was2_q) begin
          ev_d = dead2_q ? apct_pkg::EvNone : apct_pkg::EvBegin;
        end else begin
          ev_d = dead2_q ? apct_pkg::EvEnd : apct_pkg::EvStay;
        end
      end else if (was2_q) begin
        ev_d = apct_pkg::EvEnd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) begin
      idx1_q  <= idx_in;
      inr1_q  <= inr_in;
      dead1_q <= either_dead_i;
      fwd1_q  <= fwd1_d;
      fwdv1_q <= overlap_i;
    end
    if (ctrl_i.adv2) begin
      idx2_q  <= idx1_q;
      inr2_q  <= inr1_q;
      dead2_q <= dead1_q;
      was2_q  <= was2_d;
    end
    if (ctrl_i.adv3) begin
      ev_q <= ev_d;
      ov_q <= overlap_i;
    end
  end

  assign clear_done_o    = clr_done_q;
  assign contact_event_o = ev_q;
  assign overlapping_o   = ov_q;

endmodule

>>> hw/rtl/aabb_pair_contact_tracker.sv
// aabb_pair_contact_tracker: top level, handshake and stage valid bits
// depends on apct_pkg, apct_geom, apct_track (and apct_ram below it)
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | ids, centres, sizes, either_dead_i
//  out     | out_valid_o / out_ready_i | contact_event_o, overlapping_o
//
// three register stages: stage 1, stage 2 and the output stage; one item can be
// taken every cycle while the output is not held by out_ready_i, same pair back to
// back included
// the table ram has one write port, so after reset a clearing pass over its 4096
// entries (one entry a cycle) runs before in_ready_o rises
// a stage moves whenever the stage after it is empty or moves, so bubbles close up
// while the output waits and nothing is lost or repeated

module aabb_pair_contact_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [apct_pkg::IdW-1:0]          first_id_i,
  input  logic [apct_pkg::IdW-1:0]          second_id_i,
  input  logic signed [apct_pkg::CoordW-1:0] first_cx_i,
  input  logic signed [apct_pkg::CoordW-1:0] first_cy_i,
  input  logic signed [apct_pkg::CoordW-1:0] second_cx_i,
  input  logic signed [apct_pkg::CoordW-1:0] second_cy_i,
  input  logic [apct_pkg::SizeW-1:0]        first_w_i,
  input  logic [apct_pkg::SizeW-1:0]        first_h_i,
  input  logic [apct_pkg::SizeW-1:0]        second_w_i,
  input  logic [apct_pkg::SizeW-1:0]        second_h_i,
  input  logic                              either_dead_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        contact_event_o,
  output logic                              overlapping_o
);

  logic v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic en1, en2, en3;
  logic clear_done, overlap;
  apct_pkg::pipe_ctrl_t ctrl;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_ready_o = en1 && clear_done;

  assign ctrl.acc  = in_valid_i && in_ready_o;
  assign ctrl.adv2 = en2 && v1_q;
  assign ctrl.adv3 = en3 && v2_q;

  assign v1_d = en1 ? ctrl.acc : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  apct_geom u_geom (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .first_cx_i  (first_cx_i),
    .first_cy_i  (first_cy_i),
    .second_cx_i (second_cx_i),
    .second_cy_i (second_cy_i),
    .first_w_i   (first_w_i),
    .first_h_i   (first_h_i),
    .second_w_i  (second_w_i),
    .second_h_i  (second_h_i),
    .overlap_o   (overlap)
  );

  apct_track u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .first_id_i      (first_id_i),
    .second_id_i     (second_id_i),
    .either_dead_i   (either_dead_i),
    .overlap_i       (overlap),
    .clear_done_o    (clear_done),
    .contact_event_o (contact_event_o),
    .overlapping_o   (overlapping_o)
  );

  assign out_valid_o = v3_q;

endmodule
